/* sv/ttip_pkg.sv */
// ----------------------------------------------------------------------------
// ttip_pkg
// shared codes and controller/datapath link types for the telnet input parser
// ----------------------------------------------------------------------------
`default_nettype none

package ttip_pkg;

  // result kinds
  localparam logic [1:0] KIND_KEY  = 2'd0;
  localparam logic [1:0] KIND_ECHO = 2'd1;
  localparam logic [1:0] KIND_CHAR = 2'd2;
  localparam logic [1:0] KIND_END  = 2'd3;

  // navigation key codes
  localparam logic [3:0] NAV_NONE   = 4'd0;
  localparam logic [3:0] NAV_UP     = 4'd1;
  localparam logic [3:0] NAV_DOWN   = 4'd2;
  localparam logic [3:0] NAV_RIGHT  = 4'd3;
  localparam logic [3:0] NAV_LEFT   = 4'd4;
  localparam logic [3:0] NAV_HOME   = 4'd5;
  localparam logic [3:0] NAV_END    = 4'd6;
  localparam logic [3:0] NAV_INSERT = 4'd7;
  localparam logic [3:0] NAV_DELETE = 4'd8;
  localparam logic [3:0] NAV_PGUP   = 4'd9;
  localparam logic [3:0] NAV_PGDN   = 4'd10;

  // telnet command tracking
  localparam logic [2:0] IAC_NONE  = 3'd0;
  localparam logic [2:0] IAC_CMD   = 3'd1;
  localparam logic [2:0] IAC_OPT   = 3'd2;
  localparam logic [2:0] IAC_SUB   = 3'd3;
  localparam logic [2:0] IAC_SUBIAC = 3'd4;

  // escape tracking
  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_SEEN = 2'd1;
  localparam logic [1:0] ESC_CSI  = 2'd2;

  // special bytes
  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_ESC  = 8'h1B;
  localparam logic [7:0] B_DEL  = 8'h7F;
  localparam logic [7:0] B_BS   = 8'h08;
  localparam logic [7:0] B_EOT  = 8'h04;
  localparam logic [7:0] B_TAB  = 8'h09;
  localparam logic [7:0] B_LF   = 8'h0A;
  localparam logic [7:0] B_CR   = 8'h0D;
  localparam logic [7:0] B_SP   = 8'h20;
  localparam logic [7:0] B_CTRL_MAX = 8'd26;

  // decode outcome of one byte
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_ONE  = 2'd1;
  localparam logic [1:0] ACT_BKSP = 2'd2;
  localparam logic [1:0] ACT_LINE = 2'd3;

  // output register source select
  localparam logic [2:0] SEL_PEND = 3'd0;
  localparam logic [2:0] SEL_BS   = 3'd1;
  localparam logic [2:0] SEL_SP   = 3'd2;
  localparam logic [2:0] SEL_CR   = 3'd3;
  localparam logic [2:0] SEL_LF   = 3'd4;
  localparam logic [2:0] SEL_CHAR = 3'd5;
  localparam logic [2:0] SEL_END  = 3'd6;

  typedef struct packed {
    logic       take;
    logic       parse;
    logic       load;
    logic [2:0] sel;
    logic       last;
    logic       idx_clr;
    logic       idx_inc;
    logic       fill_clr;
  } ttip_cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       out_free;
    logic       fill_zero;
    logic       idx_last;
  } ttip_stat_t;

endpackage

`default_nettype wire

/* sv/ttip_dp.sv */
// ----------------------------------------------------------------------------
// ttip_dp
// parse state, line store, pending result and output register
// ----------------------------------------------------------------------------
`default_nettype none

module ttip_dp #(
  parameter int LINE_CAPACITY = 32
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      cfg_we,
  input  wire                      cfg_wdata,
  input  wire  [7:0]               rx_byte,
  input  wire                      out_stall,
  input  wire  ttip_pkg::ttip_cmd_t cmd,
  output ttip_pkg::ttip_stat_t     stat,
  output logic                     out_valid,
  output logic [1:0]               kind,
  output logic [7:0]               byte_value,
  output logic [7:0]               key_ascii,
  output logic                     ctrl_combo,
  output logic [3:0]               nav_key,
  output logic [5:0]               line_length,
  output logic                     last
);

  localparam int FW = $clog2(LINE_CAPACITY);

  logic              program_mode;
  logic [7:0]        rx_q;
  logic [2:0]        iac_phase, iac_phase_next;
  logic [1:0]        escape_phase, escape_phase_next;
  logic [15:0]       escape_number, escape_number_next;
  logic [FW-1:0]     line_fill;
  logic [FW-1:0]     char_idx;
  logic [6:0]        line_store [LINE_CAPACITY];
  logic [6:0]        rd_data;

  logic [1:0]        act;
  logic              fill_inc, fill_dec;
  logic [1:0]        p_kind_next;
  logic [7:0]        p_byte_next, p_ascii_next;
  logic              p_ctrl_next;
  logic [3:0]        p_nav_next;
  logic [1:0]        pend_kind;
  logic [7:0]        pend_byte, pend_ascii;
  logic              pend_ctrl;
  logic [3:0]        pend_nav;
  logic [3:0]        nav;

  // csi final byte to navigation key
  always_comb begin
    nav = ttip_pkg::NAV_NONE;
    case (rx_q)
      8'h41: nav = ttip_pkg::NAV_UP;
      8'h42: nav = ttip_pkg::NAV_DOWN;
      8'h43: nav = ttip_pkg::NAV_RIGHT;
      8'h44: nav = ttip_pkg::NAV_LEFT;
      8'h48: nav = ttip_pkg::NAV_HOME;
      8'h46: nav = ttip_pkg::NAV_END;
      8'h7E: begin
        if (escape_number == 16'd2) nav = ttip_pkg::NAV_INSERT;
        else if (escape_number == 16'd3) nav = ttip_pkg::NAV_DELETE;
        else if (escape_number == 16'd5) nav = ttip_pkg::NAV_PGUP;
        else if (escape_number == 16'd6) nav = ttip_pkg::NAV_PGDN;
      end
      default: nav = ttip_pkg::NAV_NONE;
    endcase
  end

  // byte decode
  always_comb begin
    iac_phase_next     = iac_phase;
    escape_phase_next  = escape_phase;
    escape_number_next = escape_number;
    act          = ttip_pkg::ACT_NONE;
    fill_inc     = 1'b0;
    fill_dec     = 1'b0;
    p_kind_next  = ttip_pkg::KIND_KEY;
    p_byte_next  = rx_q;
    p_ascii_next = rx_q;
    p_ctrl_next  = 1'b0;
    p_nav_next   = ttip_pkg::NAV_NONE;
    if (iac_phase != ttip_pkg::IAC_NONE) begin
      case (iac_phase)
        ttip_pkg::IAC_CMD: begin
          if (rx_q == ttip_pkg::B_SB) iac_phase_next = ttip_pkg::IAC_SUB;
          else if (rx_q >= ttip_pkg::B_WILL && rx_q <= ttip_pkg::B_DONT)
            iac_phase_next = ttip_pkg::IAC_OPT;
          else iac_phase_next = ttip_pkg::IAC_NONE;
        end
        ttip_pkg::IAC_SUB: begin
          if (rx_q == ttip_pkg::B_IAC) iac_phase_next = ttip_pkg::IAC_SUBIAC;
        end
        ttip_pkg::IAC_SUBIAC: begin
          iac_phase_next = (rx_q == ttip_pkg::B_SE) ? ttip_pkg::IAC_NONE : ttip_pkg::IAC_SUB;
        end
        default: iac_phase_next = ttip_pkg::IAC_NONE;
      endcase
    end else if (rx_q == ttip_pkg::B_IAC) begin
      iac_phase_next = ttip_pkg::IAC_CMD;
    end else if (escape_phase != ttip_pkg::ESC_NONE) begin
      if (escape_phase == ttip_pkg::ESC_SEEN) begin
        if (rx_q == 8'h5B) begin
          escape_phase_next  = ttip_pkg::ESC_CSI;
          escape_number_next = 16'd0;
        end else begin
          escape_phase_next = ttip_pkg::ESC_NONE;
        end
      end else if (escape_phase == ttip_pkg::ESC_CSI) begin
        if (rx_q >= 8'h30 && rx_q <= 8'h39) begin
          escape_number_next = (escape_number << 3) + (escape_number << 1)
                               + {12'd0, rx_q[3:0]};
        end else if (rx_q >= 8'h40 && rx_q <= 8'h7E) begin
          escape_phase_next = ttip_pkg::ESC_NONE;
          if (program_mode && nav != ttip_pkg::NAV_NONE) begin
            act          = ttip_pkg::ACT_ONE;
            p_byte_next  = 8'd0;
            p_ascii_next = 8'd0;
            p_nav_next   = nav;
          end
        end
      end else begin
        escape_phase_next = ttip_pkg::ESC_NONE;
      end
    end else if (rx_q == ttip_pkg::B_ESC) begin
      escape_phase_next = ttip_pkg::ESC_SEEN;
    end else if (rx_q == ttip_pkg::B_EOT) begin
      act = ttip_pkg::ACT_NONE;
    end else if (program_mode) begin
      if (rx_q != ttip_pkg::B_LF) begin
        act = ttip_pkg::ACT_ONE;
        if (rx_q >= 8'd1 && rx_q <= ttip_pkg::B_CTRL_MAX && rx_q != ttip_pkg::B_CR
            && rx_q != ttip_pkg::B_TAB && rx_q != ttip_pkg::B_BS) begin
          p_byte_next = rx_q + 8'h40;
          p_ctrl_next = 1'b1;
        end
      end
    end else if (rx_q == ttip_pkg::B_CR || rx_q == ttip_pkg::B_LF) begin
      if (!(rx_q == ttip_pkg::B_LF && line_fill == '0)) act = ttip_pkg::ACT_LINE;
    end else if (rx_q == ttip_pkg::B_DEL || rx_q == ttip_pkg::B_BS) begin
      if (line_fill != '0) begin
        act      = ttip_pkg::ACT_BKSP;
        fill_dec = 1'b1;
      end
    end else if (rx_q >= ttip_pkg::B_SP && rx_q < ttip_pkg::B_DEL
                 && line_fill < FW'(LINE_CAPACITY - 1)) begin
      act         = ttip_pkg::ACT_ONE;
      fill_inc    = 1'b1;
      p_kind_next = ttip_pkg::KIND_ECHO;
      p_ascii_next = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) rx_q <= rx_byte;
    if (cmd.parse) begin
      pend_kind  <= p_kind_next;
      pend_byte  <= p_byte_next;
      pend_ascii <= p_ascii_next;
      pend_ctrl  <= p_ctrl_next;
      pend_nav   <= p_nav_next;
    end
  end

  // line store
  always_ff @(posedge clk) begin
    if (cmd.parse && fill_inc) line_store[line_fill] <= rx_q[6:0];
    rd_data <= line_store[char_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      program_mode  <= 1'b0;
      iac_phase     <= ttip_pkg::IAC_NONE;
      escape_phase  <= ttip_pkg::ESC_NONE;
      escape_number <= 16'd0;
      line_fill     <= '0;
      char_idx      <= '0;
    end else begin
      if (cfg_we) program_mode <= cfg_wdata;
      if (cmd.parse) begin
        iac_phase     <= iac_phase_next;
        escape_phase  <= escape_phase_next;
        escape_number <= escape_number_next;
        if (fill_inc) line_fill <= line_fill + FW'(1);
        else if (fill_dec) line_fill <= line_fill - FW'(1);
      end else if (cmd.fill_clr) begin
        line_fill <= '0;
      end
      if (cmd.idx_clr) char_idx <= '0;
      else if (cmd.idx_inc) char_idx <= char_idx + FW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      last        <= cmd.last;
      kind        <= ttip_pkg::KIND_ECHO;
      byte_value  <= 8'd0;
      key_ascii   <= 8'd0;
      ctrl_combo  <= 1'b0;
      nav_key     <= ttip_pkg::NAV_NONE;
      line_length <= 6'd0;
      case (cmd.sel)
        ttip_pkg::SEL_PEND: begin
          kind       <= pend_kind;
          byte_value <= pend_byte;
          key_ascii  <= pend_ascii;
          ctrl_combo <= pend_ctrl;
          nav_key    <= pend_nav;
        end
        ttip_pkg::SEL_BS:   byte_value <= ttip_pkg::B_BS;
        ttip_pkg::SEL_SP:   byte_value <= ttip_pkg::B_SP;
        ttip_pkg::SEL_CR:   byte_value <= ttip_pkg::B_CR;
        ttip_pkg::SEL_LF:   byte_value <= ttip_pkg::B_LF;
        ttip_pkg::SEL_CHAR: begin
          kind       <= ttip_pkg::KIND_CHAR;
          byte_value <= {1'b0, rd_data};
        end
        ttip_pkg::SEL_END: begin
          kind        <= ttip_pkg::KIND_END;
          line_length <= 6'(line_fill);
        end
        default: byte_value <= 8'd0;
      endcase
    end
  end

  assign stat.act       = act;
  assign stat.out_free  = !out_valid || !out_stall;
  assign stat.fill_zero = (line_fill == '0);
  assign stat.idx_last  = (char_idx == line_fill - FW'(1));

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    line_fill <= FW'(LINE_CAPACITY - 1))
    else $error("line fill beyond capacity");
`endif

endmodule

`default_nettype wire

/* sv/ttip_ctrl.sv */
// ----------------------------------------------------------------------------
// ttip_ctrl
// sequencer: takes a byte, decodes it, then issues its results one by one
// ----------------------------------------------------------------------------
`default_nettype none

module ttip_ctrl (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire  ttip_pkg::ttip_stat_t stat,
  output ttip_pkg::ttip_cmd_t       cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PARSE = 4'd1;
  localparam logic [3:0] S_ONE   = 4'd2;
  localparam logic [3:0] S_BS1   = 4'd3;
  localparam logic [3:0] S_BS2   = 4'd4;
  localparam logic [3:0] S_BS3   = 4'd5;
  localparam logic [3:0] S_CR    = 4'd6;
  localparam logic [3:0] S_LF    = 4'd7;
  localparam logic [3:0] S_FETCH = 4'd8;
  localparam logic [3:0] S_CHAR  = 4'd9;
  localparam logic [3:0] S_END   = 4'd10;

  logic [3:0] state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.sel    = ttip_pkg::SEL_PEND;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        // no byte is taken while reset is held
        in_stall = rst;
        if (in_valid && !rst) begin
          cmd.take   = 1'b1;
          state_next = S_PARSE;
        end
      end
      S_PARSE: begin
        cmd.parse = 1'b1;
        case (stat.act)
          ttip_pkg::ACT_ONE:  state_next = S_ONE;
          ttip_pkg::ACT_BKSP: state_next = S_BS1;
          ttip_pkg::ACT_LINE: state_next = S_CR;
          default:            state_next = S_IDLE;
        endcase
      end
      S_ONE: begin
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_BS1: begin
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          cmd.sel    = ttip_pkg::SEL_BS;
          state_next = S_BS2;
        end
      end
      S_BS2: begin
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          cmd.sel    = ttip_pkg::SEL_SP;
          state_next = S_BS3;
        end
      end
      S_BS3: begin
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          cmd.sel    = ttip_pkg::SEL_BS;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CR: begin
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          cmd.sel    = ttip_pkg::SEL_CR;
          state_next = S_LF;
        end
      end
      S_LF: begin
        if (stat.out_free) begin
          cmd.load    = 1'b1;
          cmd.sel     = ttip_pkg::SEL_LF;
          cmd.idx_clr = 1'b1;
          state_next  = stat.fill_zero ? S_END : S_FETCH;
        end
      end
      S_FETCH: begin
        state_next = S_CHAR;
      end
      S_CHAR: begin
        if (stat.out_free) begin
          cmd.load    = 1'b1;
          cmd.sel     = ttip_pkg::SEL_CHAR;
          cmd.idx_inc = 1'b1;
          state_next  = stat.idx_last ? S_END : S_FETCH;
        end
      end
      S_END: begin
        if (stat.out_free) begin
          cmd.load     = 1'b1;
          cmd.sel      = ttip_pkg::SEL_END;
          cmd.last     = 1'b1;
          cmd.fill_clr = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef ASSERT_OFF
  a_parse_follows_take: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> (state == S_PARSE))
    else $error("accepted byte not decoded next cycle");
`endif

endmodule

`default_nettype wire

/* sv/telnet_terminal_input_parser.sv */
// ----------------------------------------------------------------------------
// telnet_terminal_input_parser
// telnet byte filter with csi key decoding and a line editor
// ----------------------------------------------------------------------------
//
// channel   direction  handshake             payload
// cfg       in         cfg_we                cfg_wdata (program_mode)
// rx        in         in_valid / in_stall   rx_byte
// result    out        out_valid / out_stall kind, byte_value, key_ascii,
//                                            ctrl_combo, nav_key, line_length, last
//
// each byte is taken and decoded in one decode step; the sequencer then issues its
//   results one at a time: none, one, a backspace echo, or a completed line
//   (CR, LF, stored characters, line end); each line character costs a
//   registered store read
// rst is synchronous; it clears parse state, line fill and program_mode
// a stalled result holds in the output register while the next byte is taken
//   and decoded; sequencing resumes when the register frees up
// ----------------------------------------------------------------------------
`default_nettype none

module telnet_terminal_input_parser #(
  parameter int LINE_CAPACITY = 32
) (
  input  wire        clk,
  input  wire        rst,
  // configuration
  input  wire        cfg_we,
  input  wire        cfg_wdata,
  // received bytes
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] rx_byte,
  // results
  output logic       out_valid,
  input  wire        out_stall,
  output logic [1:0] kind,
  output logic [7:0] byte_value,
  output logic [7:0] key_ascii,
  output logic       ctrl_combo,
  output logic [3:0] nav_key,
  output logic [5:0] line_length,
  output logic       last
);

  // command and status between sequencer and datapath
  ttip_pkg::ttip_cmd_t  cmd;
  ttip_pkg::ttip_stat_t stat;

  // sequencer
  ttip_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // decode, line store and output register
  ttip_dp #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .rx_byte     (rx_byte),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .kind        (kind),
    .byte_value  (byte_value),
    .key_ascii   (key_ascii),
    .ctrl_combo  (ctrl_combo),
    .nav_key     (nav_key),
    .line_length (line_length),
    .last        (last)
  );

`ifndef ASSERT_OFF
  // line length only travels on a line end
  a_len_on_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != ttip_pkg::KIND_END) |-> (line_length == 6'd0))
    else $error("line length outside line end");

  // key fields only travel on key events
  a_key_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != ttip_pkg::KIND_KEY)
      |-> (key_ascii == 8'd0 && !ctrl_combo && nav_key == ttip_pkg::NAV_NONE))
    else $error("key fields set on non-key result");

  // a line end closes the burst of its byte
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == ttip_pkg::KIND_END) |-> last)
    else $error("line end without last");
`endif

endmodule

`default_nettype wire
